// File: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character constants for the script text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int LINE_OUT_BITS   = 16;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_WORD   = 2'd2;
	localparam logic [1:0] MODE_NUMBER = 2'd3;

	localparam logic [3:0] KIND_STRING = 4'd0;
	localparam logic [3:0] KIND_PRINT  = 4'd1;
	localparam logic [3:0] KIND_IDENT  = 4'd2;
	localparam logic [3:0] KIND_NUMBER = 4'd3;
	localparam logic [3:0] KIND_PLUS   = 4'd4;
	localparam logic [3:0] KIND_EQUALS = 4'd5;
	localparam logic [3:0] KIND_LPAREN = 4'd6;
	localparam logic [3:0] KIND_RPAREN = 4'd7;
	localparam logic [3:0] KIND_EOF    = 4'd8;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [2:0] KEYWORD_LEN = 3'd5;

	typedef struct packed {
		logic       ev;
		logic [3:0] kind;
		logic [7:0] ch;
	} res_t;

	typedef struct packed {
		logic                     two;
		res_t                     first;
		res_t                     second;
		logic [LINE_OUT_BITS-1:0] line;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       line_at_one;
	} stat_t;

	function automatic logic [7:0] keyword_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h70;
			3'd1:    ch = 8'h72;
			3'd2:    ch = 8'h69;
			3'd3:    ch = 8'h6E;
			3'd4:    ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: hdl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Accepts source bytes, tracks scan mode, line count and the keyword matcher,
// and turns a byte into at most one queue command of up to two results.
// ----------------------------------------------------------------------------
module stt_front #(
	parameter int LINE_BITS = stt_pkg::LINE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    text_byte,
	input  logic          end_of_source,
	output logic          push,
	output stt_pkg::cmd_t push_data,
	output stt_pkg::stat_t status
);

	logic [1:0]           mode_q, mode_d;
	logic [2:0]           kp_q, kp_d;
	logic                 km_q, km_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [stt_pkg::LINE_OUT_BITS-1:0] line_out;

	stt_pkg::res_t pre, post, close_res;
	logic          pre_v, post_v, run_idle;
	logic          is_hi, is_letter, is_digit, is_space, is_wordch;

	generate
		if (LINE_BITS > stt_pkg::LINE_OUT_BITS) begin : g_sat
			assign line_out = (line_q[LINE_BITS-1:stt_pkg::LINE_OUT_BITS] != '0) ? '1 :
				line_q[stt_pkg::LINE_OUT_BITS-1:0];
		end else begin : g_ext
			assign line_out = stt_pkg::LINE_OUT_BITS'(line_q);
		end
	endgenerate

	assign is_hi     = text_byte[7];
	assign is_letter = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
		(text_byte >= 8'h41 && text_byte <= 8'h5A);
	assign is_digit  = text_byte >= 8'h30 && text_byte <= 8'h39;
	assign is_space  = text_byte == 8'h20 || (text_byte >= 8'h09 && text_byte <= 8'h0D);
	assign is_wordch = is_letter || is_digit || text_byte == stt_pkg::CH_UNDER;

	always_comb begin
		close_res = '0;
		close_res.ev = 1'b1;
		case (mode_q)
			stt_pkg::MODE_STRING: close_res.kind = stt_pkg::KIND_STRING;
			stt_pkg::MODE_WORD: close_res.kind = (!km_q && kp_q == stt_pkg::KEYWORD_LEN) ?
				stt_pkg::KIND_PRINT : stt_pkg::KIND_IDENT;
			default: close_res.kind = stt_pkg::KIND_NUMBER;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		kp_d     = kp_q;
		km_d     = km_q;
		line_d   = line_q;
		pre      = close_res;
		pre_v    = 1'b0;
		post     = '0;
		post_v   = 1'b0;
		run_idle = 1'b0;

		if (end_of_source) begin
			pre_v     = mode_q != stt_pkg::MODE_IDLE;
			post_v    = 1'b1;
			post.ev   = 1'b1;
			post.kind = stt_pkg::KIND_EOF;
			mode_d    = stt_pkg::MODE_IDLE;
			kp_d      = '0;
			km_d      = 1'b0;
			line_d    = LINE_BITS'(1);
		end else begin
			unique case (mode_q)
				stt_pkg::MODE_STRING: begin
					if (text_byte == stt_pkg::CH_QUOTE) begin
						pre_v  = 1'b1;
						mode_d = stt_pkg::MODE_IDLE;
						kp_d   = '0;
						km_d   = 1'b0;
					end else begin
						post_v    = 1'b1;
						post.kind = stt_pkg::KIND_STRING;
						post.ch   = text_byte;
					end
				end
				stt_pkg::MODE_WORD: begin
					if (is_wordch) begin
						if (!km_q && kp_q < stt_pkg::KEYWORD_LEN &&
							text_byte == stt_pkg::keyword_char(kp_q)) begin
							kp_d = kp_q + 3'd1;
						end else begin
							km_d = 1'b1;
						end
						post_v    = 1'b1;
						post.kind = stt_pkg::KIND_IDENT;
						post.ch   = text_byte;
					end else begin
						pre_v    = 1'b1;
						mode_d   = stt_pkg::MODE_IDLE;
						kp_d     = '0;
						km_d     = 1'b0;
						run_idle = 1'b1;
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (is_digit) begin
						post_v    = 1'b1;
						post.kind = stt_pkg::KIND_NUMBER;
						post.ch   = text_byte;
					end else begin
						pre_v    = 1'b1;
						mode_d   = stt_pkg::MODE_IDLE;
						kp_d     = '0;
						km_d     = 1'b0;
						run_idle = 1'b1;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			if (run_idle && !is_hi) begin
				if (is_space) begin
					if (text_byte == stt_pkg::CH_NEWLINE && line_q != '1) begin
						line_d = line_q + LINE_BITS'(1);
					end
				end else if (text_byte == stt_pkg::CH_QUOTE) begin
					mode_d = stt_pkg::MODE_STRING;
				end else if (is_letter) begin
					mode_d    = stt_pkg::MODE_WORD;
					kp_d      = (text_byte == stt_pkg::keyword_char(3'd0)) ? 3'd1 : 3'd0;
					km_d      = text_byte != stt_pkg::keyword_char(3'd0);
					post_v    = 1'b1;
					post.kind = stt_pkg::KIND_IDENT;
					post.ch   = text_byte;
				end else if (is_digit) begin
					mode_d    = stt_pkg::MODE_NUMBER;
					post_v    = 1'b1;
					post.kind = stt_pkg::KIND_NUMBER;
					post.ch   = text_byte;
				end else if (text_byte == stt_pkg::CH_PLUS) begin
					post_v    = 1'b1;
					post.ev   = 1'b1;
					post.kind = stt_pkg::KIND_PLUS;
				end else if (text_byte == stt_pkg::CH_EQUALS) begin
					post_v    = 1'b1;
					post.ev   = 1'b1;
					post.kind = stt_pkg::KIND_EQUALS;
				end else if (text_byte == stt_pkg::CH_LPAREN) begin
					post_v    = 1'b1;
					post.ev   = 1'b1;
					post.kind = stt_pkg::KIND_LPAREN;
				end else if (text_byte == stt_pkg::CH_RPAREN) begin
					post_v    = 1'b1;
					post.ev   = 1'b1;
					post.kind = stt_pkg::KIND_RPAREN;
				end
			end
		end
	end

	assign push             = accept && (pre_v || post_v);
	assign push_data.two    = pre_v && post_v;
	assign push_data.first  = pre_v ? pre : post;
	assign push_data.second = post;
	assign push_data.line   = line_out;

	assign status.mode        = mode_q;
	assign status.line_at_one = line_q == LINE_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			kp_q   <= '0;
			km_q   <= 1'b0;
			line_q <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			kp_q   <= kp_d;
			km_q   <= km_d;
			line_q <= line_d;
		end
	end

endmodule

// File: hdl/stt_fifo.sv
// ----------------------------------------------------------------------------
// stt_fifo
// Short command queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
module stt_fifo #(
	parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stt_pkg::cmd_t push_data,
	input  logic          pop,
	output stt_pkg::cmd_t pop_data,
	output logic          empty,
	output logic          full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	stt_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign empty    = count_q == '0;
	assign full     = count_q == CW'(DEPTH);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Holds one queued command and delivers its one or two results as output words.
// ----------------------------------------------------------------------------
module stt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  stt_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          event_res,
	output logic [3:0]    kind,
	output logic [7:0]    token_char,
	output logic [15:0]   line_number,
	output logic          last
);

	stt_pkg::cmd_t cur_q;
	logic          cur_v_q;
	logic          phase_q;
	logic          out_acc, done;
	stt_pkg::res_t sel;

	assign out_acc = cur_v_q && !out_stall;
	assign done    = out_acc && (!cur_q.two || phase_q);
	assign q_pop   = !q_empty && (!cur_v_q || done);

	assign sel         = phase_q ? cur_q.second : cur_q.first;
	assign out_valid   = cur_v_q;
	assign event_res   = sel.ev;
	assign kind        = sel.kind;
	assign token_char  = sel.ch;
	assign line_number = cur_q.line;
	assign last        = !cur_q.two || phase_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (done) begin
				cur_v_q <= 1'b0;
				phase_q <= 1'b0;
			end else if (out_acc) begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule

// File: hdl/script_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// script_text_tokenizer_unit
// Streaming tokenizer for a small script language, one source byte per word.
// ----------------------------------------------------------------------------
// The unit takes one source byte per cycle while the queue is not full and gives
// one output word per cycle while out_stall is low. Most bytes give zero or one
// word; a byte that closes a word or number and is itself a token, or an end
// marker that flushes an open token, gives two. Those extra words drain through
// a command queue of QUEUE_DEPTH entries, and the input stalls only when that
// queue is full. An accepted byte's command is registered into the queue and
// then into the back end's holding register before its word leaves.
module script_text_tokenizer_unit #(
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_res,
	output logic [3:0]  kind,
	output logic [7:0]  token_char,
	output logic [15:0] line_number,
	output logic        last
);

	logic           in_acc;
	logic           push, pop, q_empty, q_full;
	stt_pkg::cmd_t  push_data, pop_data;
	stt_pkg::stat_t status;

	assign in_stall = q_full;
	assign in_acc   = in_valid && !in_stall;

	stt_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.text_byte    (text_byte),
		.end_of_source(end_of_source),
		.push         (push),
		.push_data    (push_data),
		.status       (status)
	);

	stt_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	stt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.kind       (kind),
		.token_char (token_char),
		.line_number(line_number),
		.last       (last)
	);

	a_eof_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && end_of_source |=>
			status.mode == stt_pkg::MODE_IDLE && status.line_at_one)
		else $error("scan state not reset after end of source");

	a_second_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |=> out_valid)
		else $error("second word of a byte was dropped");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == stt_pkg::KIND_EOF |-> last && event_res)
		else $error("end of file word is not a closing last word");

endmodule
